### design/jcc_pkg.sv
package jcc_pkg;

   // input item: one joystick sample
   typedef struct packed {
      logic [7:0] x_sample;
      logic [7:0] y_sample;
      logic       button_pressed;
   } req_item_type;

   // result item
   typedef struct packed {
      logic              calibrating;
      logic signed [7:0] x_percent;
      logic signed [7:0] y_percent;
      logic [14:0]       magnitude_squared;
      logic [2:0]        direction;
      logic              button;
      logic              range_flag;
   } rsp_item_type;

   // direction codes
   typedef enum logic [2:0] {
      DIR_NEUTRAL = 3'd0,
      DIR_LEFT    = 3'd1,
      DIR_UP      = 3'd2,
      DIR_RIGHT   = 3'd3,
      DIR_DOWN    = 3'd4
   } dir_type;

   // calibration phase
   typedef enum logic [1:0] {
      PH_CENTRE  = 2'd0,
      PH_CAPTURE = 2'd1,
      PH_RUN     = 2'd2
   } phase_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_SETUP   = 3'd1,
      ST_START_X = 3'd2,
      ST_DIV_X   = 3'd3,
      ST_DIV_Y   = 3'd4,
      ST_SQUARE  = 3'd5,
      ST_RESULT  = 3'd6
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic setup;
      logic div_start;
      logic div_sel_y;
      logic store_x;
      logic store_y;
      logic square;
      logic load_rsp;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic running;
      logic div_done;
   } sts_type;

   // per-axis operands prepared for the divider
   typedef struct packed {
      logic [14:0]       dividend;
      logic [7:0]        divisor;
      logic              neg;
      logic              sat;
      logic signed [7:0] sat_val;
   } axis_prep_type;

   localparam int DIV_STEPS = 7;
   localparam int QUOT_W    = 7;
   localparam int DIV_SHIFT = DIV_STEPS - 1;

   localparam logic signed [7:0] PCT_FULL     = 8'sd100;
   localparam logic signed [7:0] PCT_FULL_NEG = -8'sd100;
   localparam logic [14:0]       PCT_SCALE    = 15'd100;
   localparam logic [14:0]       PCT_CLAMP    = 15'd101;
   localparam logic [14:0]       MAG_MAX      = 15'd20000;

   localparam logic [7:0] HIGH_RESET = 8'd0;
   localparam logic [7:0] LOW_RESET  = 8'd255;

   localparam int          RADIUS_RESET = 80;
   localparam logic [16:0] LIM_RESET    = 17'((RADIUS_RESET + 1) * (RADIUS_RESET + 1));

endpackage

### design/jcc_divider.sv
module jcc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [14:0] dividend,
   input  logic [7:0]  divisor,
   output logic [6:0]  quotient,
   output logic        done
);

   logic [2:0]  cnt_ff;
   logic        done_ff;
   logic [14:0] rem_ff;
   logic [13:0] dsh_ff;
   logic [6:0]  quot_ff;
   logic        fits;

   // one quotient bit per cycle, restoring
   assign fits = rem_ff >= {1'b0, dsh_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && (cnt_ff == 3'd1);
         if (start) begin
            cnt_ff <= 3'(jcc_pkg::DIV_STEPS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 3'd1;
         end
      end
   end

   // operand and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= dividend;
         dsh_ff  <= {6'd0, divisor} << jcc_pkg::DIV_SHIFT;
         quot_ff <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff  <= fits ? (rem_ff - {1'b0, dsh_ff}) : rem_ff;
         quot_ff <= {quot_ff[jcc_pkg::QUOT_W-2:0], fits};
         dsh_ff  <= dsh_ff >> 1;
      end
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

   // done follows the last step of a run
   a_done_after_step: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(cnt_ff) == 3'd1 && !$past(start))
      else $error("divider done without a final step");

endmodule

### design/jcc_datapath.sv
module jcc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  jcc_pkg::cmd_type      cmd,
   output jcc_pkg::sts_type      sts,
   input  jcc_pkg::req_item_type req_data,
   input  logic                  csr_write,
   input  logic [7:0]            csr_data,
   output jcc_pkg::rsp_item_type rsp_data
);

   jcc_pkg::phase_type    phase_ff;
   jcc_pkg::req_item_type sample_ff;
   logic                  calib_ff;
   logic [7:0]            x_centre_ff, y_centre_ff;
   logic [7:0]            x_high_ff, x_low_ff, y_high_ff, y_low_ff;
   logic [16:0]           lim_ff;
   logic [16:0]           lim_in;
   logic [8:0]            radius_inc;
   jcc_pkg::axis_prep_type x_prep_ff, y_prep_ff;
   logic signed [7:0]     x_pct_ff, y_pct_ff;
   logic signed [7:0]     x_pct_in, y_pct_in;
   logic [13:0]           x_sq_ff, y_sq_ff;
   jcc_pkg::rsp_item_type rsp_ff;
   jcc_pkg::rsp_item_type rsp_in;
   logic [14:0]           div_dividend;
   logic [7:0]            div_divisor;
   logic [6:0]            quotient;
   logic                  div_done;
   logic [14:0]           mag_sum;
   jcc_pkg::dir_type      dir;

   // offset, span, sign and clamp decision for one axis
   function automatic jcc_pkg::axis_prep_type prep_axis(
      input logic [7:0] s,
      input logic [7:0] c,
      input logic [7:0] hi,
      input logic [7:0] lo
   );
      jcc_pkg::axis_prep_type p;
      logic signed [8:0] off;
      logic signed [8:0] span;
      logic [7:0]        abs_off;
      logic [7:0]        abs_span;
      logic [14:0]       limit;
      logic              zero;
      logic              big;
      off      = $signed({1'b0, s}) - $signed({1'b0, c});
      span     = (s > c) ? ($signed({1'b0, hi}) - $signed({1'b0, c}))
                         : ($signed({1'b0, c}) - $signed({1'b0, lo}));
      abs_off  = off[8] ? 8'(-off) : off[7:0];
      abs_span = span[8] ? 8'(-span) : span[7:0];
      p.dividend = {7'd0, abs_off} * jcc_pkg::PCT_SCALE;
      limit      = {7'd0, abs_span} * jcc_pkg::PCT_CLAMP;
      p.divisor  = abs_span;
      p.neg      = off[8] ^ span[8];
      zero       = (span == 9'sd0);
      big        = p.dividend >= limit;
      p.sat      = zero || big;
      if (zero) begin
         if (off > 9'sd0) begin
            p.sat_val = jcc_pkg::PCT_FULL;
         end else if (off < 9'sd0) begin
            p.sat_val = jcc_pkg::PCT_FULL_NEG;
         end else begin
            p.sat_val = 8'sd0;
         end
      end else begin
         p.sat_val = p.neg ? jcc_pkg::PCT_FULL_NEG : jcc_pkg::PCT_FULL;
      end
      return p;
   endfunction

   // signed percent from quotient or saturated value
   function automatic logic signed [7:0] axis_pct(
      input jcc_pkg::axis_prep_type p,
      input logic [6:0]             q
   );
      logic signed [7:0] qext;
      qext = $signed({1'b0, q});
      if (p.sat) begin
         return p.sat_val;
      end
      return p.neg ? -qext : qext;
   endfunction

   // absolute value of a percent, at most 100
   function automatic logic [6:0] pct_abs(input logic signed [7:0] v);
      return v[7] ? 7'(-v) : v[6:0];
   endfunction

   // sector classification with integer compares
   function automatic jcc_pkg::dir_type classify(
      input logic signed [7:0] x,
      input logic signed [7:0] y
   );
      logic signed [8:0] x9, y9, nx9, ny9;
      x9  = {x[7], x};
      y9  = {y[7], y};
      nx9 = -x9;
      ny9 = -y9;
      if (y9 > x9 && y9 >= nx9) begin
         return jcc_pkg::DIR_UP;
      end
      if (x9 >= y9 && x9 > ny9) begin
         return jcc_pkg::DIR_RIGHT;
      end
      if (y9 <= nx9 && y9 < x9) begin
         return jcc_pkg::DIR_DOWN;
      end
      return jcc_pkg::DIR_LEFT;
   endfunction

   // neutral radius kept as its squared threshold
   assign radius_inc = {1'b0, csr_data} + 9'd1;
   assign lim_in     = 17'({9'd0, radius_inc} * {9'd0, radius_inc});

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= jcc_pkg::LIM_RESET;
      end else if (csr_write) begin
         lim_ff <= lim_in;
      end
   end

   // calibration state, updated when an item is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= jcc_pkg::PH_CENTRE;
         x_centre_ff <= '0;
         y_centre_ff <= '0;
         x_high_ff   <= jcc_pkg::HIGH_RESET;
         y_high_ff   <= jcc_pkg::HIGH_RESET;
         x_low_ff    <= jcc_pkg::LOW_RESET;
         y_low_ff    <= jcc_pkg::LOW_RESET;
      end else if (cmd.capture) begin
         unique case (phase_ff)
            jcc_pkg::PH_CENTRE: begin
               x_centre_ff <= req_data.x_sample;
               y_centre_ff <= req_data.y_sample;
               phase_ff    <= jcc_pkg::PH_CAPTURE;
            end
            jcc_pkg::PH_CAPTURE: begin
               if (req_data.button_pressed) begin
                  phase_ff <= jcc_pkg::PH_RUN;
               end else begin
                  if (req_data.x_sample > x_high_ff) x_high_ff <= req_data.x_sample;
                  if (req_data.y_sample > y_high_ff) y_high_ff <= req_data.y_sample;
                  if (req_data.x_sample < x_low_ff) x_low_ff <= req_data.x_sample;
                  if (req_data.y_sample < y_low_ff) y_low_ff <= req_data.y_sample;
               end
            end
            default: begin
               phase_ff <= phase_ff;
            end
         endcase
      end
   end

   // sample and operand registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_data;
         calib_ff  <= (phase_ff != jcc_pkg::PH_RUN);
      end
      if (cmd.setup) begin
         x_prep_ff <= prep_axis(sample_ff.x_sample, x_centre_ff, x_high_ff, x_low_ff);
         y_prep_ff <= prep_axis(sample_ff.y_sample, y_centre_ff, y_high_ff, y_low_ff);
      end
   end

   // shared divider, x axis first then y
   assign div_dividend = cmd.div_sel_y ? y_prep_ff.dividend : x_prep_ff.dividend;
   assign div_divisor  = cmd.div_sel_y ? y_prep_ff.divisor : x_prep_ff.divisor;

   jcc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   // percent per axis, then squares
   assign x_pct_in = axis_pct(x_prep_ff, quotient);
   assign y_pct_in = axis_pct(y_prep_ff, quotient);

   always_ff @(posedge clock) begin
      if (cmd.store_x) begin
         x_pct_ff <= x_pct_in;
      end
      if (cmd.store_y) begin
         y_pct_ff <= y_pct_in;
      end
      if (cmd.square) begin
         x_sq_ff <= {7'd0, pct_abs(x_pct_ff)} * {7'd0, pct_abs(x_pct_ff)};
         y_sq_ff <= {7'd0, pct_abs(y_pct_ff)} * {7'd0, pct_abs(y_pct_ff)};
      end
   end

   // magnitude, direction and result assembly
   assign mag_sum = {1'b0, x_sq_ff} + {1'b0, y_sq_ff};
   assign dir     = ({2'd0, mag_sum} < lim_ff) ? jcc_pkg::DIR_NEUTRAL
                                               : classify(x_pct_ff, y_pct_ff);

   always_comb begin
      rsp_in = '0;
      if (calib_ff) begin
         rsp_in.calibrating = 1'b1;
      end else begin
         rsp_in.x_percent         = x_pct_ff;
         rsp_in.y_percent         = y_pct_ff;
         rsp_in.magnitude_squared = mag_sum;
         rsp_in.direction         = dir;
         rsp_in.button            = sample_ff.button_pressed;
         rsp_in.range_flag        = x_prep_ff.sat | y_prep_ff.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data     = rsp_ff;
   assign sts.running  = (phase_ff == jcc_pkg::PH_RUN);
   assign sts.div_done = div_done;

   // scaled percent never leaves the clamp range
   a_x_pct_range: assert property (@(posedge clock) disable iff (reset)
      cmd.store_x |=> (x_pct_ff <= jcc_pkg::PCT_FULL && x_pct_ff >= jcc_pkg::PCT_FULL_NEG))
      else $error("x percent out of range");

   a_y_pct_range: assert property (@(posedge clock) disable iff (reset)
      cmd.store_y |=> (y_pct_ff <= jcc_pkg::PCT_FULL && y_pct_ff >= jcc_pkg::PCT_FULL_NEG))
      else $error("y percent out of range");

   // magnitude of a running result stays within two full deflections
   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && !calib_ff) |-> mag_sum <= jcc_pkg::MAG_MAX)
      else $error("magnitude beyond bound");

endmodule

### design/jcc_controller.sv
module jcc_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  jcc_pkg::sts_type sts,
   output jcc_pkg::cmd_type cmd
);

   jcc_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jcc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.running ? jcc_pkg::ST_SETUP : jcc_pkg::ST_RESULT;
            end
         end
         jcc_pkg::ST_SETUP: begin
            state_in = jcc_pkg::ST_START_X;
         end
         jcc_pkg::ST_START_X: begin
            state_in = jcc_pkg::ST_DIV_X;
         end
         jcc_pkg::ST_DIV_X: begin
            if (sts.div_done) state_in = jcc_pkg::ST_DIV_Y;
         end
         jcc_pkg::ST_DIV_Y: begin
            if (sts.div_done) state_in = jcc_pkg::ST_SQUARE;
         end
         jcc_pkg::ST_SQUARE: begin
            state_in = jcc_pkg::ST_RESULT;
         end
         jcc_pkg::ST_RESULT: begin
            if (rsp_free) state_in = jcc_pkg::ST_IDLE;
         end
         default: begin
            state_in = jcc_pkg::ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         jcc_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         jcc_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         jcc_pkg::ST_START_X: begin
            cmd.div_start = 1'b1;
         end
         jcc_pkg::ST_DIV_X: begin
            cmd.store_x   = sts.div_done;
            cmd.div_start = sts.div_done;
            cmd.div_sel_y = 1'b1;
         end
         jcc_pkg::ST_DIV_Y: begin
            cmd.store_y = sts.div_done;
         end
         jcc_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
         end
         jcc_pkg::ST_RESULT: begin
            cmd.load_rsp = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // output valid flag
   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jcc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // one item in flight: no second accept right after one
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in work");

   // a result is only loaded into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a waiting item");

   // the x division ends before the y division starts
   a_div_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_start && cmd.div_sel_y) |-> sts.div_done)
      else $error("y division started early");

endmodule

### design/joystick_calibrate_and_classify_core.sv
// Joystick calibration and direction classifier.
// Input channel req_valid/req_ready/req_data carries one sample per item
// (x, y, button). Output channel rsp_valid/rsp_ready/rsp_data carries one
// result item per sample. csr_valid/csr_data writes the neutral radius;
// csr_ready is always high, and writes belong to idle periods.
// After reset the first sample sets the centre, later samples widen the
// per-axis extremes, and the first sample with the button held ends
// calibration. All of these give a result with calibrating set.
// A calibrating sample goes from accept straight to the result state.
// A running sample passes through setup, the x division, the y division
// and squaring before its result. Each axis goes through one shared
// restoring divider.
// Items are handled one at a time. The result waits in an output register,
// so a new item is taken while the receiver stalls; that item then holds
// in its final step until the output register frees.
// Reset clears the calibration, sets the radius to 80 and empties the
// output register.
module joystick_calibrate_and_classify_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  jcc_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output jcc_pkg::rsp_item_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_data
);

   jcc_pkg::cmd_type cmd;
   jcc_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   jcc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   jcc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

endmodule
